>>> hw/rtl/gdw_pkg.sv
package gdw_pkg;

  localparam int MAX_ROWS    = 32;
  localparam int MAX_COLS    = 32;
  localparam int STACK_DEPTH = 2048;

  localparam int ROW_W   = 5;
  localparam int COL_W   = 5;
  localparam int CELL_N  = MAX_ROWS * MAX_COLS;
  localparam int CELL_AW = ROW_W + COL_W;
  localparam int MARK_W  = 5;
  localparam int STK_AW  = $clog2(STACK_DEPTH);
  localparam int CNT_W   = STK_AW + 1;
  localparam int SIZE_W  = 6;
  localparam int KIND_W  = 2;
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 6;

  localparam int SIDE_RT  = 0;
  localparam int SIDE_DW  = 1;
  localparam int SIDE_UP  = 2;
  localparam int SIDE_LF  = 3;
  localparam int WALL_BIT = 4;

  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BEGIN = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STEP  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CHECK = 2'd3;

  localparam logic [CFG_IW-1:0] CFG_ROWS        = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_COLS        = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_START_GIVEN = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_START_ROW   = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_START_COL   = 3'd4;

  localparam int ST_W = 5;
  localparam logic [ST_W-1:0] ST_CLR      = 5'd0;
  localparam logic [ST_W-1:0] ST_IDLE     = 5'd1;
  localparam logic [ST_W-1:0] ST_LD_RD    = 5'd2;
  localparam logic [ST_W-1:0] ST_LD_WR    = 5'd3;
  localparam logic [ST_W-1:0] ST_BG_RD    = 5'd4;
  localparam logic [ST_W-1:0] ST_BG_WR    = 5'd5;
  localparam logic [ST_W-1:0] ST_BG_START = 5'd6;
  localparam logic [ST_W-1:0] ST_SC_RD    = 5'd7;
  localparam logic [ST_W-1:0] ST_SC_TEST  = 5'd8;
  localparam logic [ST_W-1:0] ST_MB_UP    = 5'd9;
  localparam logic [ST_W-1:0] ST_MB_LF    = 5'd10;
  localparam logic [ST_W-1:0] ST_MB_DW    = 5'd11;
  localparam logic [ST_W-1:0] ST_MB_RT    = 5'd12;
  localparam logic [ST_W-1:0] ST_MB_CUR   = 5'd13;
  localparam logic [ST_W-1:0] ST_MB_WR    = 5'd14;
  localparam logic [ST_W-1:0] ST_CHK      = 5'd15;
  localparam logic [ST_W-1:0] ST_RD       = 5'd16;
  localparam logic [ST_W-1:0] ST_PATCH    = 5'd17;
  localparam logic [ST_W-1:0] ST_LOAD     = 5'd18;
  localparam logic [ST_W-1:0] ST_NRD      = 5'd19;
  localparam logic [ST_W-1:0] ST_NWR      = 5'd20;
  localparam logic [ST_W-1:0] ST_CK_RD    = 5'd21;
  localparam logic [ST_W-1:0] ST_CK_TEST  = 5'd22;
  localparam logic [ST_W-1:0] ST_OUT      = 5'd23;

  localparam int RES_W = 3;
  localparam logic [RES_W-1:0] RES_ZERO   = 3'd0;
  localparam logic [RES_W-1:0] RES_POS    = 3'd1;
  localparam logic [RES_W-1:0] RES_FIN    = 3'd2;
  localparam logic [RES_W-1:0] RES_NOCELL = 3'd3;
  localparam logic [RES_W-1:0] RES_CHECK  = 3'd4;

  typedef struct packed {
    logic [ST_W-1:0]  op;
    logic             take;
    logic             emit;
    logic [RES_W-1:0] res;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic start_ok;
    logic open;
    logic scan_last;
    logic cnt_zero;
    logic cnt_one;
    logic full;
  } stat_t;

endpackage

>>> hw/rtl/gdw_req_if.sv
interface gdw_req_if;
  import gdw_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ROW_W-1:0]  cell_row;
  logic [COL_W-1:0]  cell_col;
  logic              is_wall;

  modport source (output valid, kind, cell_row, cell_col, is_wall, input ready);
  modport sink (input valid, kind, cell_row, cell_col, is_wall, output ready);
endinterface

>>> hw/rtl/gdw_rsp_if.sv
interface gdw_rsp_if;
  import gdw_pkg::*;

  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] pos_row;
  logic [COL_W-1:0] pos_col;
  logic             finished;
  logic             unreachable;
  logic             status;

  modport source (output valid, pos_row, pos_col, finished, unreachable, status,
                  input ready);
  modport sink (input valid, pos_row, pos_col, finished, unreachable, status,
                output ready);
endinterface

>>> hw/rtl/grid_depth_first_walker.sv
// A load reads and rewrites one mark cell. A step pops finished cells off
// the stack, moves to an open side and probes the new cell's neighbours.
// A begin sweeps the mark memory, then scans for an open cell unless a valid
// start is set; a check runs all steps, then scans every used cell.
// One request at a time; the next is taken while a response waits.
// Reset (synchronous, rst high) clears the mark memory; no request is taken until that sweep ends.
module grid_depth_first_walker (
  input  logic                       clk,
  input  logic                       rst,
  gdw_req_if.sink                    req,
  gdw_rsp_if.source                  rsp,
  input  logic                       cfg_we,
  input  logic [gdw_pkg::CFG_IW-1:0] cfg_index,
  input  logic [gdw_pkg::CFG_DW-1:0] cfg_data
);
  import gdw_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  gdw_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .req_valid(req.valid), .req_kind(req.kind), .req_ready(req.ready),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
    .stat(stat), .cmd(cmd)
  );

  gdw_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .req_row(req.cell_row), .req_col(req.cell_col), .req_wall(req.is_wall),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pos_row(rsp.pos_row), .pos_col(rsp.pos_col), .finished(rsp.finished),
    .unreachable(rsp.unreachable), .status(rsp.status)
  );
endmodule

>>> hw/rtl/gdw_ram.sv
module gdw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hw/rtl/gdw_ctrl.sv
module gdw_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  input  logic [1:0]              req_kind,
  output logic                    req_ready,
  output logic                    rsp_valid,
  input  logic                    rsp_ready,
  input  gdw_pkg::stat_t          stat,
  output gdw_pkg::cmd_t           cmd
);
  import gdw_pkg::*;

  logic [ST_W-1:0]   state, state_next;
  logic [KIND_W-1:0] kind;
  logic [RES_W-1:0]  res, res_next;
  logic              take, emit;

  assign req_ready = (state == ST_IDLE);
  assign take      = req_ready && req_valid;
  assign emit      = (state == ST_OUT) && (!rsp_valid || rsp_ready);

  assign cmd.op   = state;
  assign cmd.take = take;
  assign cmd.emit = emit;
  assign cmd.res  = res;

  always_comb begin
    state_next = state;
    res_next   = res;
    unique case (state)
      ST_CLR:      if (stat.clr_last) state_next = ST_IDLE;
      ST_IDLE: begin
        if (take) begin
          unique case (req_kind)
            KIND_LOAD:  state_next = ST_LD_RD;
            KIND_BEGIN: state_next = ST_BG_RD;
            default:    state_next = ST_CHK;
          endcase
        end
      end
      ST_LD_RD:    state_next = ST_LD_WR;
      ST_LD_WR: begin
        state_next = ST_OUT;
        res_next   = RES_ZERO;
      end
      ST_BG_RD:    state_next = ST_BG_WR;
      ST_BG_WR:    state_next = stat.clr_last ? ST_BG_START : ST_BG_RD;
      ST_BG_START: state_next = stat.start_ok ? ST_MB_UP : ST_SC_RD;
      ST_SC_RD:    state_next = ST_SC_TEST;
      ST_SC_TEST: begin
        priority if (stat.open) begin
          state_next = ST_MB_UP;
        end else if (stat.scan_last) begin
          state_next = ST_OUT;
          res_next   = RES_NOCELL;
        end else begin
          state_next = ST_SC_RD;
        end
      end
      ST_MB_UP:    state_next = ST_MB_LF;
      ST_MB_LF:    state_next = ST_MB_DW;
      ST_MB_DW:    state_next = ST_MB_RT;
      ST_MB_RT:    state_next = ST_MB_CUR;
      ST_MB_CUR:   state_next = ST_MB_WR;
      ST_MB_WR: begin
        if (kind == KIND_CHECK) begin
          state_next = ST_CHK;
        end else begin
          state_next = ST_OUT;
          res_next   = RES_POS;
        end
      end
      ST_CHK: begin
        priority if (!stat.cnt_zero) begin
          state_next = ST_RD;
        end else if (kind == KIND_CHECK) begin
          state_next = ST_CK_RD;
        end else begin
          state_next = ST_OUT;
          res_next   = RES_FIN;
        end
      end
      ST_RD:       state_next = ST_PATCH;
      ST_PATCH: begin
        priority if (!stat.full) begin
          state_next = ST_NRD;
        end else if (!stat.cnt_one) begin
          state_next = ST_LOAD;
        end else if (kind == KIND_CHECK) begin
          state_next = ST_CK_RD;
        end else begin
          state_next = ST_OUT;
          res_next   = RES_FIN;
        end
      end
      ST_LOAD:     state_next = ST_RD;
      ST_NRD:      state_next = ST_NWR;
      ST_NWR:      state_next = ST_MB_UP;
      ST_CK_RD:    state_next = ST_CK_TEST;
      ST_CK_TEST: begin
        if (stat.scan_last) begin
          state_next = ST_OUT;
          res_next   = RES_CHECK;
        end else begin
          state_next = ST_CK_RD;
        end
      end
      ST_OUT:      if (emit) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      kind      <= KIND_LOAD;
      res       <= RES_ZERO;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      res   <= res_next;
      if (take) begin
        kind <= req_kind;
      end
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end
endmodule

>>> hw/rtl/gdw_datapath.sv
module gdw_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  gdw_pkg::cmd_t               cmd,
  output gdw_pkg::stat_t              stat,
  input  logic [gdw_pkg::ROW_W-1:0]   req_row,
  input  logic [gdw_pkg::COL_W-1:0]   req_col,
  input  logic                        req_wall,
  input  logic                        cfg_we,
  input  logic [gdw_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [gdw_pkg::CFG_DW-1:0]  cfg_data,
  output logic [gdw_pkg::ROW_W-1:0]   pos_row,
  output logic [gdw_pkg::COL_W-1:0]   pos_col,
  output logic                        finished,
  output logic                        unreachable,
  output logic                        status
);
  import gdw_pkg::*;

  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_ROWS - 1);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_COLS - 1);

  logic [SIZE_W-1:0]  rows_used, cols_used, rows_eff, cols_eff;
  logic               start_given;
  logic [ROW_W-1:0]   start_row;
  logic [COL_W-1:0]   start_col;

  logic [ROW_W-1:0]   cur_row, sr, lat_row;
  logic [COL_W-1:0]   cur_col, sc, lat_col;
  logic               lat_wall, lost;
  logic [CNT_W-1:0]   cnt, cnt_push;
  logic [CELL_AW-1:0] idx;
  logic [3:0]         blk, side, patch;
  logic [1:0]         dir, dir_q;
  logic [MARK_W-1:0]  m_p;

  logic               m_we;
  logic [CELL_AW-1:0] m_waddr, m_raddr;
  logic [MARK_W-1:0]  m_wdata, m_rdata;
  logic               s_we;
  logic [STK_AW-1:0]  s_waddr, s_raddr;
  logic [CELL_AW-1:0] s_wdata, s_rdata;

  gdw_ram #(.WIDTH(MARK_W), .DEPTH(CELL_N)) u_marks (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  gdw_ram #(.WIDTH(CELL_AW), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  always_comb begin
    rows_eff = rows_used;
    if (rows_used == '0) rows_eff = SIZE_W'(1);
    else if (rows_used > SIZE_W'(MAX_ROWS)) rows_eff = SIZE_W'(MAX_ROWS);
    cols_eff = cols_used;
    if (cols_used == '0) cols_eff = SIZE_W'(1);
    else if (cols_used > SIZE_W'(MAX_COLS)) cols_eff = SIZE_W'(MAX_COLS);
  end

  assign patch[SIDE_RT] = (cur_col == COL_LAST);
  assign patch[SIDE_DW] = (cur_row == ROW_LAST);
  assign patch[SIDE_UP] = (cur_row == '0);
  assign patch[SIDE_LF] = (cur_col == '0);
  assign m_p = {m_rdata[WALL_BIT], m_rdata[3:0] | patch};

  always_comb begin
    side = '0;
    dir  = 2'(SIDE_LF);
    priority if (!m_p[SIDE_RT]) begin
      side[SIDE_RT] = 1'b1;
      dir           = 2'(SIDE_RT);
    end else if (!m_p[SIDE_DW]) begin
      side[SIDE_DW] = 1'b1;
      dir           = 2'(SIDE_DW);
    end else if (!m_p[SIDE_UP]) begin
      side[SIDE_UP] = 1'b1;
      dir           = 2'(SIDE_UP);
    end else begin
      side[SIDE_LF] = 1'b1;
    end
  end

  assign cnt_push = (cnt < CNT_W'(STACK_DEPTH)) ? cnt + CNT_W'(1) : cnt;

  logic sc_end, sr_end;
  assign sc_end = ({1'b0, sc} + SIZE_W'(1)) >= cols_eff;
  assign sr_end = ({1'b0, sr} + SIZE_W'(1)) >= rows_eff;

  assign stat.clr_last  = (idx == CELL_AW'(CELL_N - 1));
  assign stat.start_ok  = start_given && ({1'b0, start_row} < rows_eff)
                          && ({1'b0, start_col} < cols_eff);
  assign stat.open      = !m_rdata[WALL_BIT];
  assign stat.scan_last = sc_end && sr_end;
  assign stat.cnt_zero  = (cnt == '0);
  assign stat.cnt_one   = (cnt == CNT_W'(1));
  assign stat.full      = &m_p[3:0];

  always_comb begin
    m_we    = 1'b0;
    m_waddr = {cur_row, cur_col};
    m_wdata = m_rdata;
    m_raddr = {cur_row, cur_col};
    s_we    = 1'b0;
    s_waddr = STK_AW'(cnt_push - CNT_W'(1));
    s_wdata = {cur_row, cur_col};
    s_raddr = STK_AW'(cnt - CNT_W'(2));
    unique case (cmd.op)
      ST_CLR: begin
        m_we    = 1'b1;
        m_waddr = idx;
        m_wdata = '0;
      end
      ST_LD_RD: m_raddr = {lat_row, lat_col};
      ST_LD_WR: begin
        m_we    = 1'b1;
        m_waddr = {lat_row, lat_col};
        m_wdata = {lat_wall, m_rdata[3:0]};
      end
      ST_BG_RD: m_raddr = idx;
      ST_BG_WR: begin
        m_we    = 1'b1;
        m_waddr = idx;
        m_wdata = {m_rdata[WALL_BIT], 4'b0};
      end
      ST_BG_START: begin
        s_we    = stat.start_ok;
        s_waddr = '0;
        s_wdata = {start_row, start_col};
      end
      ST_SC_RD, ST_CK_RD: m_raddr = {sr, sc};
      ST_SC_TEST: begin
        s_we    = stat.open;
        s_wdata = {sr, sc};
      end
      ST_MB_UP: m_raddr = {cur_row - ROW_W'(1), cur_col};
      ST_MB_LF: m_raddr = {cur_row, cur_col - COL_W'(1)};
      ST_MB_DW: m_raddr = {cur_row + ROW_W'(1), cur_col};
      ST_MB_RT: m_raddr = {cur_row, cur_col + COL_W'(1)};
      ST_MB_WR: begin
        m_we    = 1'b1;
        m_wdata = {m_rdata[WALL_BIT], m_rdata[3:0] | blk};
      end
      ST_PATCH: begin
        m_we    = 1'b1;
        m_wdata = stat.full ? m_p : (m_p | {1'b0, side});
      end
      ST_NWR: begin
        m_we = 1'b1;
        unique case (dir_q)
          2'(SIDE_RT): m_wdata[SIDE_LF] = 1'b1;
          2'(SIDE_DW): m_wdata[SIDE_UP] = 1'b1;
          2'(SIDE_UP): m_wdata[SIDE_DW] = 1'b1;
          default:     m_wdata[SIDE_RT] = 1'b1;
        endcase
        s_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_used   <= SIZE_W'(MAX_ROWS);
      cols_used   <= SIZE_W'(MAX_COLS);
      start_given <= 1'b0;
      start_row   <= '0;
      start_col   <= '0;
      cnt         <= '0;
      cur_row     <= '0;
      cur_col     <= '0;
      idx         <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ROWS:        rows_used   <= cfg_data;
          CFG_COLS:        cols_used   <= cfg_data;
          CFG_START_GIVEN: start_given <= cfg_data[0];
          CFG_START_ROW:   start_row   <= cfg_data[ROW_W-1:0];
          CFG_START_COL:   start_col   <= cfg_data[COL_W-1:0];
          default: ;
        endcase
      end
      if (cmd.take) begin
        idx <= '0;
      end
      unique case (cmd.op)
        ST_CLR, ST_BG_WR: idx <= idx + CELL_AW'(1);
        ST_BG_START: begin
          cnt <= stat.start_ok ? CNT_W'(1) : '0;
          if (stat.start_ok) begin
            cur_row <= start_row;
            cur_col <= start_col;
          end
        end
        ST_SC_TEST: begin
          if (stat.open) begin
            cnt     <= cnt_push;
            cur_row <= sr;
            cur_col <= sc;
          end
        end
        ST_PATCH: begin
          if (stat.full) begin
            cnt <= cnt - CNT_W'(1);
          end else begin
            priority if (side[SIDE_RT]) cur_col <= cur_col + COL_W'(1);
            else if (side[SIDE_DW]) cur_row <= cur_row + ROW_W'(1);
            else if (side[SIDE_UP]) cur_row <= cur_row - ROW_W'(1);
            else cur_col <= cur_col - COL_W'(1);
          end
        end
        ST_LOAD: {cur_row, cur_col} <= s_rdata;
        ST_NWR:  cnt <= cnt_push;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      lat_row  <= req_row;
      lat_col  <= req_col;
      lat_wall <= req_wall;
      lost     <= 1'b0;
    end
    unique case (cmd.op)
      ST_BG_START, ST_CHK: begin
        sr <= '0;
        sc <= '0;
      end
      ST_SC_TEST, ST_CK_TEST: begin
        if (cmd.op == ST_CK_TEST && m_rdata == '0) lost <= 1'b1;
        if (sc_end) begin
          sc <= '0;
          sr <= sr + ROW_W'(1);
        end else begin
          sc <= sc + COL_W'(1);
        end
      end
      ST_PATCH: begin
        sr    <= '0;
        sc    <= '0;
        dir_q <= dir;
      end
      ST_MB_LF: blk[SIDE_UP] <= (cur_row == '0) || m_rdata[WALL_BIT];
      ST_MB_DW: blk[SIDE_LF] <= (cur_col == '0) || m_rdata[WALL_BIT];
      ST_MB_RT: blk[SIDE_DW] <= ({1'b0, cur_row} + SIZE_W'(1) >= rows_eff)
                                || (cur_row == ROW_LAST) || m_rdata[WALL_BIT];
      ST_MB_CUR: blk[SIDE_RT] <= ({1'b0, cur_col} + SIZE_W'(1) >= cols_eff)
                                 || (cur_col == COL_LAST) || m_rdata[WALL_BIT];
      default: ;
    endcase
    if (cmd.emit) begin
      pos_row     <= (cmd.res == RES_POS) ? cur_row : '0;
      pos_col     <= (cmd.res == RES_POS) ? cur_col : '0;
      finished    <= (cmd.res == RES_FIN) || (cmd.res == RES_NOCELL)
                     || (cmd.res == RES_CHECK);
      unreachable <= (cmd.res == RES_CHECK) && lost;
      status      <= (cmd.res == RES_NOCELL);
    end
  end
endmodule

>>> hw/rtl/gdw_checker.sv
module gdw_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      req_valid,
  input logic                      req_ready,
  input logic                      rsp_valid,
  input logic                      rsp_ready,
  input logic [gdw_pkg::ROW_W-1:0] pos_row,
  input logic [gdw_pkg::COL_W-1:0] pos_col,
  input logic                      finished,
  input logic                      unreachable,
  input logic                      status
);
  import gdw_pkg::*;

  a_fin_pos: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && finished |-> pos_row == '0 && pos_col == '0)
    else $error("finished response carries a position");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (unreachable || status) |-> finished)
    else $error("check or start error without finished");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_one_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid && !req_ready)
    else $error("activity right after reset");
endmodule

bind grid_depth_first_walker gdw_checker u_gdw_checker (
  .clk(clk), .rst(rst),
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .pos_row(rsp.pos_row), .pos_col(rsp.pos_col), .finished(rsp.finished),
  .unreachable(rsp.unreachable), .status(rsp.status)
);

>>> test/tb.sv
module tb;
  import gdw_pkg::*;

  typedef struct packed {
    bit [ROW_W-1:0] pos_row;
    bit [COL_W-1:0] pos_col;
    bit             finished;
    bit             unreachable;
    bit             status;
  } walk_res_t;

  class walk_board;
    bit [MARK_W-1:0] marks [CELL_N];
    bit [ROW_W-1:0]  stk_row [STACK_DEPTH];
    bit [COL_W-1:0]  stk_col [STACK_DEPTH];
    int              depth;
    int              cur_r;
    int              cur_c;
    bit [SIZE_W-1:0] rows_reg;
    bit [SIZE_W-1:0] cols_reg;
    bit              start_on;
    bit [ROW_W-1:0]  start_r;
    bit [COL_W-1:0]  start_c;
    walk_res_t       pending [$];
    int              errors;
    int              begins, steps, checks, nocell, lost_seen, finishes;

    function new();
      foreach (marks[i]) marks[i] = '0;
      depth = 0;
      cur_r = 0;
      cur_c = 0;
      rows_reg = SIZE_W'(MAX_ROWS);
      cols_reg = SIZE_W'(MAX_COLS);
      start_on = 1'b0;
      start_r = '0;
      start_c = '0;
      errors = 0;
    endfunction

    function void write_reg(bit [CFG_IW-1:0] idx, bit [CFG_DW-1:0] val);
      case (idx)
        CFG_ROWS: rows_reg = val;
        CFG_COLS: cols_reg = val;
        CFG_START_GIVEN: start_on = val[0];
        CFG_START_ROW: start_r = val[ROW_W-1:0];
        CFG_START_COL: start_c = val[COL_W-1:0];
        default: ;
      endcase
    endfunction

    function int span_rows();
      if (rows_reg < 1) return 1;
      if (rows_reg > MAX_ROWS) return MAX_ROWS;
      return rows_reg;
    endfunction

    function int span_cols();
      if (cols_reg < 1) return 1;
      if (cols_reg > MAX_COLS) return MAX_COLS;
      return cols_reg;
    endfunction

    function bit wall_at(int r, int c);
      return marks[r * MAX_COLS + c][WALL_BIT];
    endfunction

    function void push(int r, int c);
      if (depth < STACK_DEPTH) depth++;
      stk_row[depth-1] = ROW_W'(r);
      stk_col[depth-1] = COL_W'(c);
    endfunction

    function void seal_sides();
      int nr, nc, k;
      nr = span_rows();
      nc = span_cols();
      k = cur_r * MAX_COLS + cur_c;
      if (cur_r == 0 || wall_at(cur_r - 1, cur_c)) marks[k][SIDE_UP] = 1;
      if (cur_c == 0 || wall_at(cur_r, cur_c - 1)) marks[k][SIDE_LF] = 1;
      if (cur_r + 1 >= nr || cur_r + 1 >= MAX_ROWS || wall_at(cur_r + 1, cur_c))
        marks[k][SIDE_DW] = 1;
      if (cur_c + 1 >= nc || cur_c + 1 >= MAX_COLS || wall_at(cur_r, cur_c + 1))
        marks[k][SIDE_RT] = 1;
    endfunction

    function bit advance();
      int k;
      if (depth == 0) return 1;
      forever begin
        k = cur_r * MAX_COLS + cur_c;
        if (cur_r == 0) marks[k][SIDE_UP] = 1;
        if (cur_c == 0) marks[k][SIDE_LF] = 1;
        if (cur_r + 1 >= MAX_ROWS) marks[k][SIDE_DW] = 1;
        if (cur_c + 1 >= MAX_COLS) marks[k][SIDE_RT] = 1;
        if (marks[k][3:0] != 4'hf) break;
        depth--;
        if (depth == 0) return 1;
        cur_r = stk_row[depth-1];
        cur_c = stk_col[depth-1];
      end
      k = cur_r * MAX_COLS + cur_c;
      if (!marks[k][SIDE_RT]) begin
        marks[k][SIDE_RT] = 1;
        cur_c++;
        marks[cur_r * MAX_COLS + cur_c][SIDE_LF] = 1;
      end else if (!marks[k][SIDE_DW]) begin
        marks[k][SIDE_DW] = 1;
        cur_r++;
        marks[cur_r * MAX_COLS + cur_c][SIDE_UP] = 1;
      end else if (!marks[k][SIDE_UP]) begin
        marks[k][SIDE_UP] = 1;
        cur_r--;
        marks[cur_r * MAX_COLS + cur_c][SIDE_DW] = 1;
      end else begin
        marks[k][SIDE_LF] = 1;
        cur_c--;
        marks[cur_r * MAX_COLS + cur_c][SIDE_RT] = 1;
      end
      push(cur_r, cur_c);
      seal_sides();
      return 0;
    endfunction

    function void note_request(bit [KIND_W-1:0] kind, bit [ROW_W-1:0] row,
                               bit [COL_W-1:0] col, bit wall);
      walk_res_t res;
      int nr, nc;
      bit lost;
      nr = span_rows();
      nc = span_cols();
      res = '0;
      case (kind)
        KIND_LOAD: marks[row * MAX_COLS + col][WALL_BIT] = wall;
        KIND_BEGIN: begin
          begins++;
          foreach (marks[i]) marks[i][3:0] = '0;
          depth = 0;
          if (start_on && start_r < nr && start_c < nc) push(start_r, start_c);
          for (int r = 0; r < nr && depth == 0; r++)
            for (int c = 0; c < nc && depth == 0; c++)
              if (!wall_at(r, c)) push(r, c);
          if (depth == 0) begin
            nocell++;
            res.finished = 1;
            res.status = 1;
          end else begin
            cur_r = stk_row[depth-1];
            cur_c = stk_col[depth-1];
            seal_sides();
            res.pos_row = ROW_W'(cur_r);
            res.pos_col = COL_W'(cur_c);
          end
        end
        KIND_STEP: begin
          steps++;
          if (advance()) begin
            finishes++;
            res.finished = 1;
          end else begin
            res.pos_row = ROW_W'(cur_r);
            res.pos_col = COL_W'(cur_c);
          end
        end
        default: begin
          checks++;
          lost = 0;
          while (!advance()) ;
          for (int r = 0; r < nr; r++)
            for (int c = 0; c < nc; c++)
              if (marks[r * MAX_COLS + c] == 0) lost = 1;
          lost_seen += lost;
          res.finished = 1;
          res.unreachable = lost;
        end
      endcase
      pending.push_back(res);
    endfunction

    function void check_result(walk_res_t got);
      walk_res_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected response row=%0d col=%0d fin=%0b unr=%0b st=%0b",
                 $time, got.pos_row, got.pos_col, got.finished, got.unreachable,
                 got.status);
        return;
      end
      want = pending.pop_front();
      if (want != got) begin
        errors++;
        $display("%0t: mismatch expected row=%0d col=%0d fin=%0b unr=%0b st=%0b",
                 $time, want.pos_row, want.pos_col, want.finished, want.unreachable,
                 want.status);
        $display("%0t:          actual   row=%0d col=%0d fin=%0b unr=%0b st=%0b",
                 $time, got.pos_row, got.pos_col, got.finished, got.unreachable,
                 got.status);
      end
    endfunction
  endclass

  localparam int STALL_LIMIT = 600000;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;
  bit calm = 0;
  int sent = 0;
  int quiet = 0;
  walk_board board = new();

  gdw_req_if req_ch ();
  gdw_rsp_if rsp_ch ();

  grid_depth_first_walker dut (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  initial begin
    req_ch.valid = 0;
    req_ch.kind = KIND_LOAD;
    req_ch.cell_row = '0;
    req_ch.cell_col = '0;
    req_ch.is_wall = 0;
    rsp_ch.ready = 0;
  end

  always @(negedge clk)
    rsp_ch.ready <= calm || ($urandom_range(99) >= 13);

  always @(posedge clk) begin
    walk_res_t got;
    if (rsp_ch.valid && rsp_ch.ready) begin
      got.pos_row = rsp_ch.pos_row;
      got.pos_col = rsp_ch.pos_col;
      got.finished = rsp_ch.finished;
      got.unreachable = rsp_ch.unreachable;
      got.status = rsp_ch.status;
      board.check_result(got);
    end
    if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready) || rst)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("%0t: watchdog expired, %0d responses outstanding", $time,
               board.pending.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send(bit [KIND_W-1:0] kind, bit [ROW_W-1:0] row = '0,
                      bit [COL_W-1:0] col = '0, bit wall = 1'b0);
    while (!calm && $urandom_range(99) < 13) begin
      @(negedge clk);
      req_ch.valid <= 0;
    end
    @(negedge clk);
    req_ch.valid <= 1;
    req_ch.kind <= kind;
    req_ch.cell_row <= row;
    req_ch.cell_col <= col;
    req_ch.is_wall <= wall;
    do @(posedge clk); while (!req_ch.ready);
    board.note_request(kind, row, col, wall);
    sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    req_ch.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  task automatic set_reg(bit [CFG_IW-1:0] idx, bit [CFG_DW-1:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    board.write_reg(idx, val);
  endtask

  task automatic set_grid(int rows, int cols, bit given, int sr, int sc);
    set_reg(CFG_ROWS, CFG_DW'(rows));
    set_reg(CFG_COLS, CFG_DW'(cols));
    set_reg(CFG_START_GIVEN, CFG_DW'(given));
    set_reg(CFG_START_ROW, CFG_DW'(sr));
    set_reg(CFG_START_COL, CFG_DW'(sc));
    @(negedge clk);
    cfg_we <= 0;
  endtask

  function automatic int pick_size();
    int p;
    p = $urandom_range(99);
    if (p < 70) return $urandom_range(1, 8);
    if (p < 80) return 32;
    if (p < 88) return 0;
    if (p < 94) return $urandom_range(33, 63);
    return $urandom_range(9, 31);
  endfunction

  initial begin
    int nr, nc, n, phase, wall_pct;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    send(KIND_LOAD, 5'd0, 5'd0, 1'b1);
    send(KIND_LOAD, 5'd31, 5'd31, 1'b1);
    send(KIND_LOAD, 5'd31, 5'd31, 1'b0);
    send(KIND_LOAD, 5'd0, 5'd0, 1'b0);
    send(KIND_BEGIN);
    repeat (3) send(KIND_STEP);
    send(KIND_CHECK);
    send(KIND_STEP);
    drain();

    set_grid(1, 1, 1'b0, 0, 0);
    send(KIND_LOAD, 5'd0, 5'd0, 1'b1);
    send(KIND_BEGIN);
    send(KIND_STEP);
    send(KIND_CHECK);
    drain();

    set_grid(3, 3, 1'b1, 1, 1);
    send(KIND_LOAD, 5'd1, 5'd1, 1'b1);
    send(KIND_LOAD, 5'd0, 5'd0, 1'b0);
    send(KIND_BEGIN);
    repeat (4) send(KIND_STEP);
    send(KIND_CHECK);
    drain();

    set_grid(3, 3, 1'b1, 5, 5);
    send(KIND_BEGIN);
    send(KIND_STEP);
    send(KIND_CHECK);
    drain();

    phase = 0;
    while (sent < 920) begin
      calm = (phase >= 4 && phase < 9);
      nr = pick_size();
      nc = pick_size();
      if (nr > 8 && nc > 8 && $urandom_range(3) != 0) nc = $urandom_range(1, 8);
      set_grid(nr, nc, 1'($urandom_range(1)), $urandom_range(0, 31),
               $urandom_range(0, 31));
      nr = board.span_rows();
      nc = board.span_cols();
      if ($urandom_range(3) == 0) begin
        @(negedge clk);
        set_grid(nr, nc, 1'($urandom_range(1)), $urandom_range(0, nr - 1),
                 $urandom_range(0, nc - 1));
      end
      wall_pct = $urandom_range(0, 45);
      n = (nr * nc <= 40) ? nr * nc : 20;
      for (int i = 0; i < n; i++)
        if (nr * nc <= 40)
          send(KIND_LOAD, ROW_W'(i / nc), COL_W'(i % nc),
               $urandom_range(99) < wall_pct);
        else
          send(KIND_LOAD, ROW_W'($urandom_range(0, nr - 1)),
               COL_W'($urandom_range(0, nc - 1)), $urandom_range(99) < wall_pct);
      repeat ($urandom_range(0, 2))
        send(KIND_LOAD, ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 31)),
             1'($urandom_range(1)));
      send(KIND_BEGIN);
      n = $urandom_range(0, (4 * nr * nc + 4 < 50) ? 4 * nr * nc + 4 : 50);
      for (int i = 0; i < n; i++)
        if ($urandom_range(99) < 5)
          send(KIND_W'($urandom_range(0, 3)), ROW_W'($urandom_range(0, 31)),
               COL_W'($urandom_range(0, 31)), 1'($urandom_range(1)));
        else
          send(KIND_STEP);
      if ($urandom_range(1)) send(KIND_CHECK);
      drain();
      phase++;
    end
    calm = 0;

    repeat (50) @(posedge clk);
    $display("Covered %0d requests over %0d grid settings: %0d begins (%0d with no open cell),",
             sent, phase + 4, board.begins, board.nocell);
    $display("%0d steps (%0d at walk end), %0d checks (%0d with untouched cells)",
             board.steps, board.finishes, board.checks, board.lost_seen);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
